[design/multi_channel_hysteresis_debouncer_defines.svh]
// Assertion macros shared by the checker of the hysteresis debouncer.
// No dependencies; include this file by its bare name.
`ifndef MULTI_CHANNEL_HYSTERESIS_DEBOUNCER_DEFINES_SVH
`define MULTI_CHANNEL_HYSTERESIS_DEBOUNCER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCHD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication, disabled while reset is asserted.
`define MCHD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: label");

// Next-cycle implication that is checked through reset as well.
`define MCHD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed: label");

`endif

[design/mchd_pkg.sv]
// Package of the multi-channel hysteresis debouncer: widths, codes, types.
// No dependencies; imported by the interfaces, the update, the top level and the checker.
package mchd_pkg;

  localparam int CHANNELS   = 4;
  localparam int IDX_W      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CH_FIELD_W = 2;
  localparam int COUNT_W    = 16;
  localparam int RUN_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COUNT_W-1:0] COUNT_RAIL_HI = 16'hFFFF;
  localparam logic [COUNT_W-1:0] COUNT_RAIL_LO = 16'h0000;
  localparam logic [RUN_W-1:0]   RUN_MAX       = 4'hF;

  localparam logic [COUNT_W-1:0] ENTRY_RESET    = 16'd2200;
  localparam logic [COUNT_W-1:0] EXIT_RESET     = 16'd1800;
  localparam logic [RUN_W-1:0]   DEBOUNCE_RESET = 4'd3;
  localparam logic [RUN_W-1:0]   FAULT_RESET    = 4'd3;

  // Published occupancy codes.
  typedef enum logic [1:0] {
    OCC_EMPTY   = 2'd0,
    OCC_PRESENT = 2'd1,
    OCC_FAULT   = 2'd2
  } occ_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENTRY_THRESHOLD = 2'd0,
    REG_EXIT_THRESHOLD  = 2'd1,
    REG_DEBOUNCE_LENGTH = 2'd2,
    REG_FAULT_LIMIT     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [COUNT_W-1:0] entry_threshold;
    logic [COUNT_W-1:0] exit_threshold;
    logic [RUN_W-1:0]   debounce_length;
    logic [RUN_W-1:0]   fault_limit;
  } cfg_t;

  typedef struct packed {
    logic                  mode;
    logic [CH_FIELD_W-1:0] channel;
    logic                  mux_ack;
    logic                  probe_ok;
    logic [COUNT_W-1:0]    sample_count;
  } item_t;

  // One memory word per channel.
  typedef struct packed {
    occ_t               published;
    occ_t               candidate;
    logic [RUN_W-1:0]   agree_run;
    logic [RUN_W-1:0]   failure_run;
    logic [COUNT_W-1:0] stored_count;
    logic               present;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

  localparam chan_state_t STATE_RESET = '{
    published:    OCC_FAULT,
    candidate:    OCC_FAULT,
    agree_run:    '0,
    failure_run:  '0,
    stored_count: '0,
    present:      1'b0
  };

  typedef struct packed {
    logic                  write;
    logic [CH_FIELD_W-1:0] out_channel;
    occ_t                  occupancy;
    logic                  changed;
    logic [COUNT_W-1:0]    recent_count;
  } result_t;

  function automatic logic ch_in_range(input logic [CH_FIELD_W-1:0] ch);
    return 32'(ch) < CHANNELS;
  endfunction

  function automatic logic [IDX_W-1:0] ch_to_idx(input logic [CH_FIELD_W-1:0] ch);
    return IDX_W'(ch);
  endfunction

endpackage

[design/mchd_if.sv]
// Valid/ready channel interfaces for the input items and the result beats.
// Depends on mchd_pkg.
interface mchd_in_if import mchd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  mode;
  logic [CH_FIELD_W-1:0] channel;
  logic                  mux_ack;
  logic                  probe_ok;
  logic [COUNT_W-1:0]    sample_count;

  modport source (output valid, mode, channel, mux_ack, probe_ok, sample_count,
                  input ready);
  modport sink   (input valid, mode, channel, mux_ack, probe_ok, sample_count,
                  output ready);
endinterface

interface mchd_out_if import mchd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CH_FIELD_W-1:0] out_channel;
  logic [1:0]            occupancy;
  logic                  changed;
  logic [COUNT_W-1:0]    recent_count;

  modport source (output valid, out_channel, occupancy, changed, recent_count,
                  input ready);
  modport sink   (input valid, out_channel, occupancy, changed, recent_count,
                  output ready);
endinterface

[design/mchd_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module mchd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write first in program order; a same-edge read returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/mchd_update.sv]
// Per-channel update: probe reset, read checks, hysteresis and debounce.
// Depends on mchd_pkg; purely combinational.
module mchd_update import mchd_pkg::*; (
  input  cfg_t        cfg,
  input  item_t       item,
  input  chan_state_t cur,
  output chan_state_t nxt,
  output result_t     res
);

  logic             read_ok;
  occ_t             want;
  logic [RUN_W-1:0] run;
  logic [RUN_W-1:0] fails;

  // Classification against the thresholds with a dead band.
  always_comb begin
    if (item.sample_count >= cfg.entry_threshold) begin
      want = OCC_PRESENT;
    end else if (item.sample_count < cfg.exit_threshold) begin
      want = OCC_EMPTY;
    end else if (cur.published == OCC_FAULT) begin
      want = OCC_EMPTY;
    end else begin
      want = cur.published;
    end
  end

  assign read_ok = item.mux_ack && cur.present &&
                   (item.sample_count != COUNT_RAIL_LO) &&
                   (item.sample_count != COUNT_RAIL_HI);

  // Run length when the sample argues for a new state.
  assign run = (want != cur.candidate) ? RUN_W'(1) :
               (cur.agree_run < RUN_MAX) ? cur.agree_run + RUN_W'(1) : cur.agree_run;

  assign fails = (cur.failure_run < RUN_MAX) ? cur.failure_run + RUN_W'(1)
                                             : cur.failure_run;

  // Next channel state.
  always_comb begin
    nxt = cur;
    if (item.mode) begin
      nxt           = STATE_RESET;
      nxt.present   = item.probe_ok;
      nxt.published = item.probe_ok ? OCC_EMPTY : OCC_FAULT;
    end else if (read_ok) begin
      nxt.stored_count = item.sample_count;
      nxt.failure_run  = '0;
      if (want == cur.published) begin
        nxt.agree_run = '0;
      end else begin
        nxt.candidate = want;
        if (run >= cfg.debounce_length) begin
          nxt.published = want;
          nxt.agree_run = '0;
        end else begin
          nxt.agree_run = run;
        end
      end
    end else begin
      nxt.failure_run = fails;
      if (fails >= cfg.fault_limit) begin
        nxt.published = OCC_FAULT;
        nxt.agree_run = '0;
      end
    end
  end

  // Result beat; a channel beyond the configured count touches no state.
  always_comb begin
    res.out_channel = item.channel;
    if (ch_in_range(item.channel)) begin
      res.write        = 1'b1;
      res.occupancy    = nxt.published;
      res.changed      = nxt.published != cur.published;
      res.recent_count = nxt.stored_count;
    end else begin
      res.write        = 1'b0;
      res.occupancy    = OCC_FAULT;
      res.changed      = 1'b0;
      res.recent_count = '0;
    end
  end

endmodule

[design/multi_channel_hysteresis_debouncer.sv]
// Multi-channel hysteresis debouncer: one item per cycle while the output
// accepts results. An input beat is registered along with its state RAM read,
// then the update for it lands in the output register.
// Same-channel items back to back are served by forwarding the last write.
// Reset clears the per-channel valid bits (all channels read as fault) and
// loads the register defaults; no clearing pass is needed.
module multi_channel_hysteresis_debouncer import mchd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  mchd_in_if.sink               in_s,
  mchd_out_if.source            out_m,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t          cfg_r;
  logic          s1_vld_r;
  item_t         s1_item_r;
  logic          s1_adv;
  logic          in_take;
  logic [IDX_W-1:0] raddr;
  logic [STATE_W-1:0] rdata;
  logic [CHANNELS-1:0] valid_r;
  logic          rd_vld_r;
  logic          wb_vld_r;
  logic [IDX_W-1:0] wb_idx_r;
  chan_state_t   wb_data_r;
  chan_state_t   cur;
  chan_state_t   nxt;
  result_t       res;
  logic          out_vld_r;
  result_t       out_r;
  item_t         in_item;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry_threshold <= ENTRY_RESET;
      cfg_r.exit_threshold  <= EXIT_RESET;
      cfg_r.debounce_length <= DEBOUNCE_RESET;
      cfg_r.fault_limit     <= FAULT_RESET;
    end else if (cfg_wr_en) begin
      case (reg_idx_t'(cfg_index))
        REG_ENTRY_THRESHOLD: cfg_r.entry_threshold <= cfg_data;
        REG_EXIT_THRESHOLD:  cfg_r.exit_threshold  <= cfg_data;
        REG_DEBOUNCE_LENGTH: cfg_r.debounce_length <= cfg_data[RUN_W-1:0];
        REG_FAULT_LIMIT:     cfg_r.fault_limit     <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the update stage moves on when the output register frees up.
  assign s1_adv     = s1_vld_r && (!out_vld_r || out_m.ready);
  assign in_s.ready = !s1_vld_r || s1_adv;
  assign in_take    = in_s.valid && in_s.ready;

  assign in_item = '{mode: in_s.mode, channel: in_s.channel, mux_ack: in_s.mux_ack,
                     probe_ok: in_s.probe_ok, sample_count: in_s.sample_count};

  // While stalled, re-read the held item's channel so the RAM data stays current.
  assign raddr = in_s.ready ? ch_to_idx(in_s.channel) : ch_to_idx(s1_item_r.channel);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_s.ready) begin
      s1_vld_r <= in_take;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
  end

  mchd_ram #(.WIDTH(STATE_W), .DEPTH(CHANNELS)) u_state_ram (
    .clk   (clk),
    .we    (s1_adv && res.write),
    .waddr (ch_to_idx(s1_item_r.channel)),
    .wdata (nxt),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Valid bits: an entry never written reads as the reset state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
      wb_vld_r <= 1'b0;
    end else begin
      if (s1_adv && res.write) begin
        valid_r[ch_to_idx(s1_item_r.channel)] <= 1'b1;
      end
      rd_vld_r <= (32'(raddr) < CHANNELS) ? valid_r[raddr] : 1'b0;
      wb_vld_r <= s1_adv && res.write;
    end
  end

  // Forwarding copy of the word written at the last edge.
  always_ff @(posedge clk) begin
    if (s1_adv && res.write) begin
      wb_idx_r  <= ch_to_idx(s1_item_r.channel);
      wb_data_r <= nxt;
    end
  end

  always_comb begin
    if (wb_vld_r && (wb_idx_r == ch_to_idx(s1_item_r.channel))) begin
      cur = wb_data_r;
    end else if (rd_vld_r) begin
      cur = chan_state_t'(rdata);
    end else begin
      cur = STATE_RESET;
    end
  end

  mchd_update u_update (
    .cfg  (cfg_r),
    .item (s1_item_r),
    .cur  (cur),
    .nxt  (nxt),
    .res  (res)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_m.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= res;
    end
  end

  assign out_m.valid        = out_vld_r;
  assign out_m.out_channel  = out_r.out_channel;
  assign out_m.occupancy    = out_r.occupancy;
  assign out_m.changed      = out_r.changed;
  assign out_m.recent_count = out_r.recent_count;

endmodule

[design/mchd_checker.sv]
// Port-level checker for the hysteresis debouncer, bound to the top level.
// Depends on mchd_pkg and multi_channel_hysteresis_debouncer_defines.svh.
`include "multi_channel_hysteresis_debouncer_defines.svh"

module mchd_checker import mchd_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         occupancy,
  input logic               changed,
  input logic [COUNT_W-1:0] recent_count
);

  // The input side only stalls when a result waits in the output register.
  `MCHD_ASSERT_NOW(a_stall_only_when_full, clk, rst_n, !in_ready, out_valid)

  // A result beat never carries an undefined occupancy code.
  `MCHD_ASSERT_NOW(a_occ_code, clk, rst_n, out_valid, occupancy != 2'd3)

  // A stalled result beat holds its payload.
  `MCHD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready,
                    out_valid && $stable(occupancy) && $stable(changed) &&
                    $stable(recent_count))

  // Nothing is presented right after reset.
  `MCHD_ASSERT_NEXT_ALWAYS(a_reset_quiet, clk, !rst_n, !out_valid)

  // An open input with no beat leaves the update stage empty, so a free or
  // draining output register in the next cycle shows no result after that.
  `MCHD_ASSERT_NEXT(a_no_invented, clk, rst_n,
                    (in_ready && !in_valid) ##1 (!out_valid || out_ready),
                    !out_valid)

endmodule

bind multi_channel_hysteresis_debouncer mchd_checker u_mchd_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_s.valid),
  .in_ready     (in_s.ready),
  .out_valid    (out_m.valid),
  .out_ready    (out_m.ready),
  .occupancy    (out_m.occupancy),
  .changed      (out_m.changed),
  .recent_count (out_m.recent_count)
);

[test/tb_top.sv]
// Testbench of the multi-channel hysteresis debouncer: directed and random
// items with a predictor checked against every result beat.
// Depends on mchd_pkg, the mchd_in_if/mchd_out_if interfaces and the block.
module tb_top;
  import mchd_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 140;
  localparam int RANDOM_PHASES = 8;

  // Count bands relative to the current thresholds.
  typedef enum int {
    BAND_HIGH,
    BAND_LOW,
    BAND_DEAD,
    BAND_RAIL,
    BAND_ANY
  } band_t;

  // One predicted result beat.
  typedef struct packed {
    logic [CH_FIELD_W-1:0] channel;
    occ_t                  occupancy;
    logic                  changed;
    logic [COUNT_W-1:0]    recent_count;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mchd_in_if  in_if();
  mchd_out_if out_if();

  multi_channel_hysteresis_debouncer DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_s      (in_if),
    .out_m     (out_if),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // Shadow copy of the configuration registers.
  logic [COUNT_W-1:0] entry_thr = ENTRY_RESET;
  logic [COUNT_W-1:0] exit_thr  = EXIT_RESET;
  logic [RUN_W-1:0]   deb_len   = DEBOUNCE_RESET;
  logic [RUN_W-1:0]   fault_lim = FAULT_RESET;

  // Shadow copy of the per-channel state.
  occ_t               pub_st[CHANNELS];
  occ_t               cand_st[CHANNELS];
  logic [RUN_W-1:0]   agree[CHANNELS];
  logic [RUN_W-1:0]   fails[CHANNELS];
  logic [COUNT_W-1:0] kept_count[CHANNELS];
  logic               present[CHANNELS];

  item_t    pending_items[$];
  outcome_t expected_outcomes[$];
  int       fail_count = 0;
  int       checked_beats = 0;
  int       cycle_count = 0;

  // Works out the published state after one item and updates the shadow state.
  function automatic outcome_t classify_item(input item_t it);
    outcome_t r;
    int unsigned c;
    occ_t prior;
    occ_t want;
    logic good;
    c = it.channel;
    r.channel = it.channel;
    if (c >= CHANNELS) begin
      r.occupancy = OCC_FAULT;
      r.changed = 1'b0;
      r.recent_count = '0;
      return r;
    end
    prior = pub_st[c];
    if (it.mode) begin
      present[c] = it.probe_ok;
      pub_st[c] = it.probe_ok ? OCC_EMPTY : OCC_FAULT;
      cand_st[c] = OCC_FAULT;
      agree[c] = '0;
      fails[c] = '0;
      kept_count[c] = '0;
    end else begin
      good = it.mux_ack && present[c] && it.sample_count != COUNT_RAIL_LO
             && it.sample_count != COUNT_RAIL_HI;
      if (good) begin
        kept_count[c] = it.sample_count;
        if (it.sample_count >= entry_thr) want = OCC_PRESENT;
        else if (it.sample_count < exit_thr) want = OCC_EMPTY;
        else want = (pub_st[c] == OCC_FAULT) ? OCC_EMPTY : pub_st[c];
        if (want == pub_st[c]) begin
          agree[c] = '0;
        end else begin
          if (want != cand_st[c]) begin
            cand_st[c] = want;
            agree[c] = 4'd1;
          end else if (agree[c] != RUN_MAX) begin
            agree[c] = agree[c] + 4'd1;
          end
          // A debounce length of zero behaves as one here.
          if (agree[c] >= deb_len) begin
            pub_st[c] = want;
            agree[c] = '0;
          end
        end
        fails[c] = '0;
      end else begin
        if (fails[c] != RUN_MAX) fails[c] = fails[c] + 4'd1;
        if (fails[c] >= fault_lim) begin
          pub_st[c] = OCC_FAULT;
          agree[c] = '0;
        end
      end
    end
    r.occupancy = pub_st[c];
    r.changed = (pub_st[c] != prior);
    r.recent_count = kept_count[c];
    return r;
  endfunction

  function automatic item_t make_poll(input logic [CH_FIELD_W-1:0] ch,
                                      input logic [COUNT_W-1:0] cnt, input logic ack);
    item_t it;
    it.mode = 1'b0;
    it.channel = ch;
    it.mux_ack = ack;
    it.probe_ok = 1'($urandom);
    it.sample_count = cnt;
    return it;
  endfunction

  function automatic item_t make_probe(input logic [CH_FIELD_W-1:0] ch, input logic ok);
    item_t it;
    it.mode = 1'b1;
    it.channel = ch;
    it.mux_ack = 1'($urandom);
    it.probe_ok = ok;
    it.sample_count = 16'($urandom);
    return it;
  endfunction

  function automatic logic [COUNT_W-1:0] count_in_band(input band_t b);
    logic [COUNT_W-1:0] v;
    case (b)
      BAND_HIGH: v = 16'($urandom_range(65535, int'(entry_thr)));
      BAND_LOW: v = (exit_thr == 0) ? 16'($urandom)
                                    : 16'($urandom_range(int'(exit_thr) - 1, 0));
      BAND_DEAD: v = (exit_thr < entry_thr)
                     ? 16'($urandom_range(int'(entry_thr) - 1, int'(exit_thr)))
                     : 16'($urandom);
      BAND_RAIL: v = $urandom_range(0, 1) ? COUNT_RAIL_HI : COUNT_RAIL_LO;
      default: v = 16'($urandom);
    endcase
    return v;
  endfunction

  // Register write on the plain write port; the shadow copy follows it.
  task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_ENTRY_THRESHOLD: entry_thr = val;
      REG_EXIT_THRESHOLD: exit_thr = val;
      REG_DEBOUNCE_LENGTH: deb_len = val[RUN_W-1:0];
      REG_FAULT_LIMIT: fault_lim = val[RUN_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input int ent, input int ext, input int deb, input int flt);
    write_reg(REG_ENTRY_THRESHOLD, 16'(ent));
    write_reg(REG_EXIT_THRESHOLD, 16'(ext));
    write_reg(REG_DEBOUNCE_LENGTH, 16'(deb));
    write_reg(REG_FAULT_LIMIT, 16'(flt));
    @(negedge clk);
  endtask

  // Waits at falling edges until every item has gone through and come back.
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || expected_outcomes.size() != 0 || in_if.valid);
    repeat (4) @(negedge clk);
  endtask

  // Streaks of polls on one channel in one band, with probes and noise mixed in.
  task automatic queue_random(input int n);
    int left;
    int streak;
    int roll;
    logic [CH_FIELD_W-1:0] ch;
    band_t b;
    for (int c = 0; c < CHANNELS; c++) pending_items.push_back(make_probe(2'(c), 1'b1));
    left = n;
    while (left > 0) begin
      ch = 2'($urandom_range(0, CHANNELS - 1));
      b = band_t'($urandom_range(0, 2));
      streak = $urandom_range(1, 18);
      repeat (streak) begin
        roll = $urandom_range(0, 99);
        if (roll < 4)
          pending_items.push_back(make_probe(ch, $urandom_range(0, 4) != 0));
        else if (roll < 10)
          pending_items.push_back(make_poll(ch, 16'($urandom), 1'b0));
        else if (roll < 17)
          pending_items.push_back(make_poll(2'($urandom_range(0, CHANNELS - 1)),
                                            count_in_band(band_t'($urandom_range(0, 4))),
                                            1'b1));
        else
          pending_items.push_back(make_poll(ch, count_in_band(b), 1'b1));
        left--;
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  int    burst_left = 8;
  int    gap_left = 0;
  item_t offered;
  item_t accepted_item;

  initial begin
    in_if.valid = 1'b0;
    in_if.mode = 1'b0;
    in_if.channel = '0;
    in_if.mux_ack = 1'b0;
    in_if.probe_ok = 1'b0;
    in_if.sample_count = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        accepted_item.mode = in_if.mode;
        accepted_item.channel = in_if.channel;
        accepted_item.mux_ack = in_if.mux_ack;
        accepted_item.probe_ok = in_if.probe_ok;
        accepted_item.sample_count = in_if.sample_count;
        expected_outcomes.push_back(classify_item(accepted_item));
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left != 0 || pending_items.size() == 0) begin
          if (gap_left != 0) gap_left--;
          in_if.valid <= 1'b0;
        end else begin
          offered = pending_items.pop_front();
          in_if.valid <= 1'b1;
          in_if.mode <= offered.mode;
          in_if.channel <= offered.channel;
          in_if.mux_ack <= offered.mux_ack;
          in_if.probe_ok <= offered.probe_ok;
          in_if.sample_count <= offered.sample_count;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // Receiver: a stall style that changes now and then, plus one long hold-off.
  int stall_style = 0;
  int style_left = 100;
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else if (!hold_done && checked_beats >= 500 && pending_items.size() > 30) begin
      hold_done = 1'b1;
      hold_left = 300;
      out_if.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style = $urandom_range(0, 3);
        style_left = $urandom_range(20, 200);
      end else begin
        style_left--;
      end
      case (stall_style)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= 1'($urandom);
        2: out_if.ready <= (cycle_count % 5) != 0;
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Monitor: each result beat against the oldest expected outcome.
  outcome_t due;

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_outcomes.size() == 0) begin
        $error("result beat for channel %0d with no outcome expected", out_if.out_channel);
        fail_count++;
      end else begin
        due = expected_outcomes.pop_front();
        if (out_if.out_channel !== due.channel) begin
          $error("out_channel: expected %0d, actual %0d", due.channel, out_if.out_channel);
          fail_count++;
        end
        if (out_if.occupancy !== due.occupancy) begin
          $error("occupancy: expected %0d, actual %0d", due.occupancy, out_if.occupancy);
          fail_count++;
        end
        if (out_if.changed !== due.changed) begin
          $error("changed: expected %0d, actual %0d", due.changed, out_if.changed);
          fail_count++;
        end
        if (out_if.recent_count !== due.recent_count) begin
          $error("recent_count: expected %0d, actual %0d", due.recent_count,
                 out_if.recent_count);
          fail_count++;
        end
      end
      checked_beats++;
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < CHANNELS; c++) begin
      pub_st[c] = OCC_FAULT;
      cand_st[c] = OCC_FAULT;
      agree[c] = '0;
      fails[c] = '0;
      kept_count[c] = '0;
      present[c] = 1'b0;
    end
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed items under the reset thresholds.
    pending_items.push_back(make_poll(2'd0, 16'd3000, 1'b1));   // sensor absent
    pending_items.push_back(make_poll(2'd1, 16'd3000, 1'b0));
    pending_items.push_back(make_probe(2'd0, 1'b1));
    pending_items.push_back(make_probe(2'd1, 1'b0));
    pending_items.push_back(make_probe(2'd2, 1'b1));
    pending_items.push_back(make_probe(2'd3, 1'b1));
    pending_items.push_back(make_poll(2'd0, COUNT_RAIL_LO, 1'b1));
    pending_items.push_back(make_poll(2'd0, COUNT_RAIL_HI, 1'b1));
    pending_items.push_back(make_poll(2'd0, 16'd3000, 1'b0));   // third failure: fault
    repeat (3) pending_items.push_back(make_poll(2'd0, 16'd3000, 1'b1));
    pending_items.push_back(make_poll(2'd0, 16'd2000, 1'b1));   // dead band holds
    pending_items.push_back(make_poll(2'd0, 16'd65534, 1'b1));
    pending_items.push_back(make_poll(2'd0, 16'd1, 1'b1));
    pending_items.push_back(make_poll(2'd0, 16'd2199, 1'b1));
    repeat (3) pending_items.push_back(make_poll(2'd0, 16'd1799, 1'b1));
    pending_items.push_back(make_poll(2'd2, 16'd2000, 1'b1));
    pending_items.push_back(make_poll(2'd1, 16'd3000, 1'b1));
    repeat (3) pending_items.push_back(make_poll(2'd3, 16'd2000, 1'b0));
    pending_items.push_back(make_poll(2'd3, 16'd1800, 1'b1));   // dead band from fault
    wait_idle();

    // Fixed settings with the extremes, then random ones.
    set_config(1000, 500, 0, 0);
    queue_random(PHASE_ITEMS);
    wait_idle();
    set_config(0, 0, 1, 1);
    queue_random(PHASE_ITEMS);
    wait_idle();
    set_config(65535, 65535, 15, 15);
    queue_random(PHASE_ITEMS);
    wait_idle();
    set_config(65535, 0, 15, 1);
    queue_random(PHASE_ITEMS);
    wait_idle();
    repeat (RANDOM_PHASES) begin
      if ($urandom_range(0, 4) == 0) begin
        set_config($urandom_range(0, 65535), $urandom_range(0, 65535),
                   $urandom_range(0, 15), $urandom_range(0, 15));
      end else begin
        set_config($urandom_range(2000, 65000), $urandom_range(100, 1999),
                   $urandom_range(1, 6), $urandom_range(1, 6));
      end
      queue_random(PHASE_ITEMS);
      wait_idle();
    end

    repeat (6) @(posedge clk);
    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+design
design/mchd_pkg.sv
design/mchd_if.sv
design/mchd_ram.sv
design/mchd_update.sv
design/multi_channel_hysteresis_debouncer.sv
design/mchd_checker.sv
test/tb_top.sv
